// ===== hdl/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg
// Shared constants of the byte stream tokenizer: widths, keyword tables.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned LINE_BITS_DEF   = 20;
  localparam int unsigned COLUMN_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned KIND_W = 5;
  localparam int unsigned IVAL_W = 31;
  localparam int unsigned NKW    = 10;

  localparam logic [4:0] KIND_INT    = 5'd26;
  localparam logic [4:0] KIND_STRING = 5'd27;
  localparam logic [4:0] KIND_IDENT  = 5'd29;
  localparam logic [4:0] KIND_EOF    = 5'd30;
  localparam logic [4:0] KIND_ERROR  = 5'd31;
  localparam logic [4:0] KIND_LPAREN = 5'd0;
  localparam logic [4:0] KIND_RPAREN = 5'd1;
  localparam logic [4:0] KIND_COLON  = 5'd17;

  localparam logic [1:0] ERR_UNTERM = 2'd1;
  localparam logic [1:0] ERR_BANG   = 2'd2;
  localparam logic [1:0] ERR_SYMBOL = 2'd3;

  localparam logic [2:0] KW_LEN [NKW] = '{3'd4, 3'd5, 3'd2, 3'd4, 3'd4,
                                          3'd3, 3'd3, 3'd3, 3'd3, 3'd4};
  localparam logic [4:0] KW_KIND [NKW] = '{5'd28, 5'd28, 5'd18, 5'd19, 5'd20,
                                           5'd21, 5'd22, 5'd23, 5'd24, 5'd25};

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] i);
    logic [39:0] txt;
    case (k)
      4'd0:    txt = "true ";
      4'd1:    txt = "false";
      4'd2:    txt = "if   ";
      4'd3:    txt = "else ";
      4'd4:    txt = "then ";
      4'd5:    txt = "end  ";
      4'd6:    txt = "not  ";
      4'd7:    txt = "var  ";
      4'd8:    txt = "int  ";
      default: txt = "bool ";
    endcase
    case (i)
      3'd0:    kw_char = txt[39:32];
      3'd1:    kw_char = txt[31:24];
      3'd2:    kw_char = txt[23:16];
      3'd3:    kw_char = txt[15:8];
      default: kw_char = txt[7:0];
    endcase
  endfunction

endpackage

// ===== hdl/bst_front.sv =====
// ----------------------------------------------------------------------------
// bst_front
// Scanner: a byte a cycle unless stalled; updates state, forms up to 2 tokens.
// ----------------------------------------------------------------------------
module bst_front
  import bst_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  localparam int unsigned TOK_W  = KIND_W + IVAL_W + 1 + 2 * OFFSET_BITS + LINE_BITS
                                   + COLUMN_BITS + 2 + 8,
  localparam int unsigned PAIR_W = 2 + 2 * TOK_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  output logic              byte_ready_o,
  input  logic [7:0]        byte_i,
  output logic              pair_valid_o,
  input  logic              pair_ready_i,
  output logic [PAIR_W-1:0] pair_o
);

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WORD, MODE_NUM, MODE_STR, MODE_OP
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [7:0]             pend_q, pend_d;
  logic [NKW-1:0]         kwm_q, kwm_d;
  logic [OFFSET_BITS-1:0] wlen_q, wlen_d;
  logic [IVAL_W-1:0]      acc_q, acc_d;
  logic                   asat_q, asat_d, ddone_q, ddone_d, halt_q, halt_d;
  logic [LINE_BITS-1:0]   sl_q, sl_d, cl_q, cl_d;
  logic [COLUMN_BITS-1:0] sc_q, sc_d, cc_q, cc_d;
  logic [OFFSET_BITS-1:0] so_q, so_d, co_q, co_d;

  logic                   a_v, b_v, cons, run_idle, fire;
  logic [TOK_W-1:0]       a_tok, b_tok;
  logic [7:0]             c;
  logic [IVAL_W+3:0]      prod;

  function automatic logic [TOK_W-1:0] make_tok(
    input logic [4:0] kind, input logic [IVAL_W-1:0] ival, input logic sat,
    input logic [OFFSET_BITS-1:0] off, input logic [OFFSET_BITS-1:0] len,
    input logic [LINE_BITS-1:0] line, input logic [COLUMN_BITS-1:0] col,
    input logic [1:0] err, input logic [7:0] bad);
    make_tok = {bad, err, col, line, len, off, sat, ival, kind};
  endfunction

  function automatic logic [NKW-1:0] next_kwm(input logic [NKW-1:0] m,
                                              input logic [OFFSET_BITS-1:0] wl,
                                              input logic [7:0] ch);
    logic [NKW-1:0] r;
    r = m;
    for (int k = 0; k < NKW; k++) begin
      if (wl >= OFFSET_BITS'(KW_LEN[k]) || kw_char(4'(k), wl[2:0]) != ch) begin
        r[k] = 1'b0;
      end
    end
    next_kwm = r;
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] s, input logic eq);
    case (s)
      "=":     op_kind = eq ? 5'd3 : 5'd2;
      "!":     op_kind = 5'd4;
      "<":     op_kind = eq ? 5'd6 : 5'd5;
      ">":     op_kind = eq ? 5'd8 : 5'd7;
      "+":     op_kind = eq ? 5'd10 : 5'd9;
      "-":     op_kind = eq ? 5'd12 : 5'd11;
      "*":     op_kind = eq ? 5'd14 : 5'd13;
      default: op_kind = eq ? 5'd16 : 5'd15;
    endcase
  endfunction

  function automatic logic [OFFSET_BITS-1:0] inc_o(input logic [OFFSET_BITS-1:0] v);
    inc_o = (&v) ? v : v + 1'b1;
  endfunction

  logic is_space, is_digit, is_alpha, is_wordch;
  assign c         = byte_i;
  assign is_space  = (c == " ") || (c >= 8'd9 && c <= 8'd13);
  assign is_digit  = (c >= "0") && (c <= "9");
  assign is_alpha  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_wordch = is_alpha || is_digit || (c == "_");
  assign prod      = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + (IVAL_W+4)'(c - "0");

  assign byte_ready_o = pair_ready_i;
  assign fire         = byte_valid_i && byte_ready_o;

  always_comb begin
    mode_d = mode_q; pend_d = pend_q; kwm_d = kwm_q; wlen_d = wlen_q;
    acc_d = acc_q; asat_d = asat_q; ddone_d = ddone_q; halt_d = halt_q;
    sl_d = sl_q; sc_d = sc_q; so_d = so_q; cl_d = cl_q; cc_d = cc_q; co_d = co_q;
    a_v = 1'b0; b_v = 1'b0; a_tok = '0; b_tok = '0; cons = 1'b0; run_idle = 1'b0;
    if (halt_q) begin
      if (c == 8'd0) begin
        halt_d = 1'b0;
        mode_d = MODE_IDLE; pend_d = '0; kwm_d = '1; wlen_d = '0; acc_d = '0;
        asat_d = 1'b0; ddone_d = 1'b0; sl_d = '0; sc_d = '0; so_d = '0;
        cl_d = '0; cc_d = '0; co_d = '0;
      end
    end else begin
      unique case (mode_q)
        MODE_WORD: begin
          if (is_wordch) begin
            kwm_d = next_kwm(kwm_q, wlen_q, c);
            wlen_d = inc_o(wlen_q);
            cons = 1'b1;
          end else begin
            a_v = 1'b1;
            a_tok = make_tok(KIND_IDENT, '0, 1'b0, so_q, wlen_q, sl_q, sc_q, 2'd0, 8'd0);
            for (int k = NKW - 1; k >= 0; k--) begin
              if (kwm_q[k] && wlen_q == OFFSET_BITS'(KW_LEN[k])) begin
                a_tok = make_tok(KW_KIND[k], IVAL_W'(k == 0), 1'b0, '0, '0, sl_q, sc_q,
                                 2'd0, 8'd0);
              end
            end
            mode_d = MODE_IDLE;
            run_idle = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_wordch) begin
            if (!ddone_q && is_digit) begin
              if (prod > (IVAL_W+4)'({IVAL_W{1'b1}})) begin
                acc_d = '1;
                asat_d = 1'b1;
              end else begin
                acc_d = prod[IVAL_W-1:0];
              end
            end else begin
              ddone_d = 1'b1;
            end
            cons = 1'b1;
          end else begin
            a_v = 1'b1;
            a_tok = make_tok(KIND_INT, acc_q, asat_q, '0, '0, sl_q, sc_q, 2'd0, 8'd0);
            mode_d = MODE_IDLE;
            run_idle = 1'b1;
          end
        end
        MODE_STR: begin
          if (c == 8'd0) begin
            a_v = 1'b1;
            a_tok = make_tok(KIND_ERROR, '0, 1'b0, '0, '0, sl_q, sc_q, ERR_UNTERM, 8'd0);
            mode_d = MODE_IDLE; pend_d = '0; kwm_d = '1; wlen_d = '0; acc_d = '0;
            asat_d = 1'b0; ddone_d = 1'b0; sl_d = '0; sc_d = '0; so_d = '0;
            cl_d = '0; cc_d = '0; co_d = '0;
          end else if (c == "\"") begin
            a_v = 1'b1;
            a_tok = make_tok(KIND_STRING, '0, 1'b0, so_q, wlen_q, sl_q, sc_q, 2'd0, 8'd0);
            mode_d = MODE_IDLE;
            cons = 1'b1;
          end else begin
            wlen_d = inc_o(wlen_q);
            cons = 1'b1;
          end
        end
        MODE_OP: begin
          a_v = 1'b1;
          if (c == "=") begin
            a_tok = make_tok(op_kind(pend_q, 1'b1), '0, 1'b0, '0, '0, sl_q, sc_q,
                             2'd0, 8'd0);
            mode_d = MODE_IDLE;
            cons = 1'b1;
          end else if (pend_q == "!") begin
            a_tok = make_tok(KIND_ERROR, '0, 1'b0, '0, '0, sl_q, sc_q, ERR_BANG, "!");
            if (c == 8'd0) begin
              mode_d = MODE_IDLE; pend_d = '0; kwm_d = '1; wlen_d = '0; acc_d = '0;
              asat_d = 1'b0; ddone_d = 1'b0; sl_d = '0; sc_d = '0; so_d = '0;
              cl_d = '0; cc_d = '0; co_d = '0;
            end else begin
              halt_d = 1'b1;
            end
          end else begin
            a_tok = make_tok(op_kind(pend_q, 1'b0), '0, 1'b0, '0, '0, sl_q, sc_q,
                             2'd0, 8'd0);
            mode_d = MODE_IDLE;
            run_idle = 1'b1;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          run_idle = 1'b1;
        end
      endcase

      if (run_idle) begin
        if (is_space) begin
          cons = 1'b1;
        end else begin
          sl_d = cl_q; sc_d = cc_q; so_d = co_q;
          if (c == "\"") begin
            so_d = inc_o(co_q);
            wlen_d = '0;
            mode_d = MODE_STR;
            cons = 1'b1;
          end else if (is_digit) begin
            acc_d = IVAL_W'(c - "0");
            asat_d = 1'b0;
            ddone_d = 1'b0;
            mode_d = MODE_NUM;
            cons = 1'b1;
          end else if (is_alpha) begin
            kwm_d = next_kwm('1, '0, c);
            wlen_d = OFFSET_BITS'(1);
            mode_d = MODE_WORD;
            cons = 1'b1;
          end else if (c == "(" || c == ")" || c == ":") begin
            b_v = 1'b1;
            b_tok = make_tok(c == "(" ? KIND_LPAREN : (c == ")" ? KIND_RPAREN : KIND_COLON),
                             '0, 1'b0, '0, '0, cl_q, cc_q, 2'd0, 8'd0);
            cons = 1'b1;
          end else if (c == "=" || c == "!" || c == "<" || c == ">" ||
                       c == "+" || c == "-" || c == "*" || c == "/") begin
            pend_d = c;
            mode_d = MODE_OP;
            cons = 1'b1;
          end else if (c == 8'd0) begin
            b_v = 1'b1;
            b_tok = make_tok(KIND_EOF, '0, 1'b0, '0, '0, cl_q, cc_q, 2'd0, 8'd0);
            mode_d = MODE_IDLE; pend_d = '0; kwm_d = '1; wlen_d = '0; acc_d = '0;
            asat_d = 1'b0; ddone_d = 1'b0; sl_d = '0; sc_d = '0; so_d = '0;
            cl_d = '0; cc_d = '0; co_d = '0;
          end else begin
            b_v = 1'b1;
            b_tok = make_tok(KIND_ERROR, '0, 1'b0, '0, '0, cl_q, cc_q, ERR_SYMBOL, c);
            halt_d = 1'b1;
          end
        end
      end

      if (cons) begin
        if (c == "\n") begin
          cc_d = '0;
          cl_d = (&cl_q) ? cl_q : cl_q + 1'b1;
        end else begin
          cc_d = (&cc_q) ? cc_q : cc_q + 1'b1;
        end
        co_d = inc_o(co_q);
      end
    end
  end

  always_comb begin
    pair_valid_o = fire && (a_v || b_v);
    if (a_v && b_v) begin
      pair_o = {2'd2, b_tok, a_tok};
    end else if (a_v) begin
      pair_o = {2'd1, {TOK_W{1'b0}}, a_tok};
    end else begin
      pair_o = {2'd1, {TOK_W{1'b0}}, b_tok};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE; pend_q <= '0; kwm_q <= '1; wlen_q <= '0; acc_q <= '0;
      asat_q <= 1'b0; ddone_q <= 1'b0; halt_q <= 1'b0;
      sl_q <= '0; sc_q <= '0; so_q <= '0; cl_q <= '0; cc_q <= '0; co_q <= '0;
    end else if (fire) begin
      mode_q <= mode_d; pend_q <= pend_d; kwm_q <= kwm_d; wlen_q <= wlen_d;
      acc_q <= acc_d; asat_q <= asat_d; ddone_q <= ddone_d; halt_q <= halt_d;
      sl_q <= sl_d; sc_q <= sc_d; so_q <= so_d; cl_q <= cl_d; cc_q <= cc_d; co_q <= co_d;
    end
  end

endmodule

// ===== hdl/bst_fifo.sv =====
// ----------------------------------------------------------------------------
// bst_fifo
// Short register queue between scanner and output stage.
// ----------------------------------------------------------------------------
module bst_fifo
  import bst_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue overfilled");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count lost a push");
  a_ptr_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> wr_q == rd_q) else $error("pointers differ on empty");

endmodule

// ===== hdl/bst_back.sv =====
// ----------------------------------------------------------------------------
// bst_back
// Output stage: unpacks token pairs into single output beats.
// ----------------------------------------------------------------------------
module bst_back
  import bst_pkg::*;
#(
  parameter int unsigned TOK_W = 8,
  localparam int unsigned PAIR_W = 2 + 2 * TOK_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pair_valid_i,
  output logic              pair_ready_o,
  input  logic [PAIR_W-1:0] pair_i,
  output logic              tok_valid_o,
  input  logic              tok_ready_i,
  output logic [TOK_W-1:0]  tok_o,
  output logic              tok_last_o
);

  logic [PAIR_W-1:0] pair_q;
  logic              full_q, sel_q;
  logic              two, done;

  assign two          = (pair_q[PAIR_W-1 -: 2] == 2'd2);
  assign tok_valid_o  = full_q;
  assign tok_o        = sel_q ? pair_q[2*TOK_W-1:TOK_W] : pair_q[TOK_W-1:0];
  assign tok_last_o   = sel_q || !two;
  assign done         = full_q && tok_ready_i && tok_last_o;
  assign pair_ready_o = !full_q || done;

  always_ff @(posedge clk_i) begin
    if (pair_valid_i && pair_ready_o) begin
      pair_q <= pair_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      sel_q  <= 1'b0;
    end else if (pair_ready_o) begin
      full_q <= pair_valid_i;
      sel_q  <= 1'b0;
    end else if (tok_ready_i) begin
      sel_q <= 1'b1;
    end
  end

  a_sel_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (full_q && two)) else $error("second beat of a single pair");
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q && tok_ready_i && !tok_last_o) |=> (sel_q && full_q))
    else $error("pair did not advance");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q && !tok_ready_i) |=> $stable(sel_q)) else $error("beat moved while stalled");

endmodule

// ===== hdl/byte_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// byte_stream_tokenizer
// Streaming lexer: source bytes in, tokens with position and value out.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while the queue has room; a scanner
// updates the lexer state in that cycle and forms the zero, one or two
// tokens that byte completes. These pass through a two-entry queue to an
// output stage that sends one token per beat, so the sustained rate is one
// byte per cycle while tokens are at most one per byte. A zero byte ends the
// source; after an error the block drops bytes up to and including the next
// zero byte. Token kind travels on tuser.
// ----------------------------------------------------------------------------
module byte_stream_tokenizer
  import bst_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  localparam int unsigned TOK_W   = KIND_W + IVAL_W + 1 + 2 * OFFSET_BITS + LINE_BITS
                                    + COLUMN_BITS + 2 + 8,
  localparam int unsigned RAW_W   = TOK_W - KIND_W,
  localparam int unsigned TDATA_W = ((RAW_W + 7) / 8) * 8,
  localparam int unsigned PAIR_W  = 2 + 2 * TOK_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // src_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // int_value, number_saturated, tok_offset, tok_length, tok_line, tok_column,
  // error_code, bad_char, zero pad
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [4:0]         m_axis_tuser,   // token_kind
  output logic               m_axis_tlast
);

  logic              pv, pr, qv, qr;
  logic [PAIR_W-1:0] pd, qd;
  logic [TOK_W-1:0]  tok;

  bst_front #(
    .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk_i, .rst_ni,
    .byte_valid_i(s_axis_tvalid), .byte_ready_o(s_axis_tready), .byte_i(s_axis_tdata),
    .pair_valid_o(pv), .pair_ready_i(pr), .pair_o(pd)
  );

  bst_fifo #(.WIDTH(PAIR_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(pv), .push_ready_o(pr), .push_data_i(pd),
    .pop_valid_o(qv), .pop_ready_i(qr), .pop_data_o(qd)
  );

  bst_back #(.TOK_W(TOK_W)) u_back (
    .clk_i, .rst_ni,
    .pair_valid_i(qv), .pair_ready_o(qr), .pair_i(qd),
    .tok_valid_o(m_axis_tvalid), .tok_ready_i(m_axis_tready),
    .tok_o(tok), .tok_last_o(m_axis_tlast)
  );

  assign m_axis_tuser = tok[KIND_W-1:0];
  assign m_axis_tdata = TDATA_W'(tok[TOK_W-1:KIND_W]);

endmodule

// ===== tb/sv/byte_stream_tokenizer_test.sv =====
// ----------------------------------------------------------------------------
// byte_stream_tokenizer_test
// Drives source bytes into the tokenizer and checks every token beat against
// a cycle-free lexer model kept in the testbench, with random stalls on both
// streams and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module byte_stream_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bst_pkg::*;

  localparam int unsigned TDW = 128;

  typedef struct packed {
    logic [4:0]  kind;
    logic [30:0] ival;
    logic        sat;
    logic [23:0] off;
    logic [23:0] len;
    logic [19:0] line;
    logic [15:0] col;
    logic [1:0]  err;
    logic [7:0]  bad;
    logic        lst;
  } token_t;

  typedef enum logic [2:0] {ST_IDLE, ST_WORD, ST_NUM, ST_STR, ST_OP} scan_e;

  localparam logic [23:0] OFF_MAX  = 24'hFFFFFF;
  localparam logic [19:0] LINE_MAX = 20'hFFFFF;
  localparam logic [15:0] COL_MAX  = 16'hFFFF;

  class token_scoreboard;
    scan_e       mode;
    logic [7:0]  pend;
    logic [9:0]  kw_hit;
    logic [23:0] wlen, s_off, c_off;
    logic [31:0] acc;
    logic        acc_sat, dig_done, halted;
    logic [19:0] s_line, c_line;
    logic [15:0] s_col, c_col;
    token_t      expq[$];
    token_t      fresh[$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = ST_IDLE; pend = 0; kw_hit = '1; wlen = 0; acc = 0;
      acc_sat = 0; dig_done = 0; halted = 0;
      s_line = 0; s_col = 0; s_off = 0; c_line = 0; c_col = 0; c_off = 0;
    endfunction

    function bit is_sp(logic [7:0] c);
      return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction
    function bit is_alf(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function bit is_wch(logic [7:0] c);
      return is_alf(c) || is_dig(c) || c == "_";
    endfunction

    function void advance(logic [7:0] c);
      if (c == 8'h0A) begin
        c_col = 0;
        if (c_line != LINE_MAX) c_line++;
      end else if (c_col != COL_MAX) begin
        c_col++;
      end
      if (c_off != OFF_MAX) c_off++;
    endfunction

    function void push(logic [4:0] k, logic [30:0] v, logic s, logic [23:0] o,
                       logic [23:0] l, logic [1:0] e, logic [7:0] b);
      token_t t;
      t.kind = k; t.ival = v; t.sat = s; t.off = o; t.len = l; t.line = s_line;
      t.col = s_col; t.err = e; t.bad = b; t.lst = 0;
      fresh.push_back(t);
    endfunction

    function void feed_kw(logic [7:0] c);
      for (int k = 0; k < NKW; k++)
        if (wlen >= KW_LEN[k] || kw_char(4'(k), wlen[2:0]) != c) kw_hit[k] = 0;
      if (wlen != OFF_MAX) wlen++;
    endfunction

    function void close_word();
      for (int k = 0; k < NKW; k++)
        if (kw_hit[k] && wlen == KW_LEN[k]) begin
          push(KW_KIND[k], 31'(k == 0), 0, 0, 0, 0, 0);
          return;
        end
      push(KIND_IDENT, 0, 0, s_off, wlen, 0, 0);
    endfunction

    function logic [4:0] op_code(logic [7:0] s, bit eq);
      case (s)
        "=": return eq ? 5'd3 : 5'd2;
        "!": return 5'd4;
        "<": return eq ? 5'd6 : 5'd5;
        ">": return eq ? 5'd8 : 5'd7;
        "+": return eq ? 5'd10 : 5'd9;
        "-": return eq ? 5'd12 : 5'd11;
        "*": return eq ? 5'd14 : 5'd13;
        default: return eq ? 5'd16 : 5'd15;
      endcase
    endfunction

    function void scan_idle(logic [7:0] c);
      if (is_sp(c)) begin
        advance(c);
        return;
      end
      s_line = c_line; s_col = c_col; s_off = c_off;
      if (c == "\"") begin
        s_off = (c_off != OFF_MAX) ? c_off + 1 : c_off;
        wlen = 0; mode = ST_STR; advance(c);
      end else if (is_dig(c)) begin
        acc = c - "0"; acc_sat = 0; dig_done = 0; mode = ST_NUM; advance(c);
      end else if (is_alf(c)) begin
        kw_hit = '1; wlen = 0; feed_kw(c); mode = ST_WORD; advance(c);
      end else if (c == "(" || c == ")" || c == ":") begin
        push(c == "(" ? KIND_LPAREN : (c == ")" ? KIND_RPAREN : KIND_COLON),
             0, 0, 0, 0, 0, 0);
        advance(c);
      end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "+" ||
                   c == "-" || c == "*" || c == "/") begin
        pend = c; mode = ST_OP; advance(c);
      end else if (c == 0) begin
        push(KIND_EOF, 0, 0, 0, 0, 0, 0);
        clear();
      end else begin
        push(KIND_ERROR, 0, 0, 0, 0, ERR_SYMBOL, c);
        halted = 1;
      end
    endfunction

    function void note_byte(logic [7:0] c);
      logic [35:0] v;
      fresh.delete();
      if (halted) begin
        if (c == 0) clear();
        return;
      end
      case (mode)
        ST_WORD: begin
          if (is_wch(c)) begin
            feed_kw(c); advance(c); return;
          end
          close_word(); mode = ST_IDLE; scan_idle(c);
        end
        ST_NUM: begin
          if (is_wch(c)) begin
            if (!dig_done && is_dig(c)) begin
              v = acc * 10 + (c - "0");
              if (v > 36'h7FFFFFFF) begin
                v = 36'h7FFFFFFF; acc_sat = 1;
              end
              acc = v[31:0];
            end else begin
              dig_done = 1;
            end
            advance(c);
            return;
          end
          push(KIND_INT, acc[30:0], acc_sat, 0, 0, 0, 0);
          mode = ST_IDLE; scan_idle(c);
        end
        ST_STR: begin
          if (c == 0) begin
            push(KIND_ERROR, 0, 0, 0, 0, ERR_UNTERM, 0); clear();
          end else if (c == "\"") begin
            push(KIND_STRING, 0, 0, s_off, wlen, 0, 0); mode = ST_IDLE; advance(c);
          end else begin
            if (wlen != OFF_MAX) wlen++;
            advance(c);
          end
        end
        ST_OP: begin
          if (c == "=") begin
            push(op_code(pend, 1), 0, 0, 0, 0, 0, 0); mode = ST_IDLE; advance(c);
          end else if (pend == "!") begin
            push(KIND_ERROR, 0, 0, 0, 0, ERR_BANG, "!");
            if (c == 0) clear(); else halted = 1;
          end else begin
            push(op_code(pend, 0), 0, 0, 0, 0, 0, 0); mode = ST_IDLE; scan_idle(c);
          end
        end
        default: scan_idle(c);
      endcase
      if (fresh.size() > 0) fresh[fresh.size()-1].lst = 1;
      foreach (fresh[i]) expq.push_back(fresh[i]);
    endfunction

    function void check_token(token_t got);
      token_t w;
      if (expq.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected token: got %p", got);
        return;
      end
      w = expq.pop_front();
      if (got !== w) begin
        errors++;
        if (errors <= 10) $display("token mismatch: expected %p actual %p", w, got);
      end
    endfunction
  endclass

  logic           clk_i, rst_ni;
  logic           s_axis_tvalid, s_axis_tready;
  logic [7:0]     s_axis_tdata;
  logic           m_axis_tvalid, m_axis_tready;
  logic [TDW-1:0] m_axis_tdata;
  logic [4:0]     m_axis_tuser;
  logic           m_axis_tlast;

  token_scoreboard sb;
  token_t got;
  bit   no_idle, hold_off, stim_done;
  int   quiet_cycles;
  byte  src[$];

  byte_stream_tokenizer u_dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_byte(byte c);
    if (!no_idle)
      while ($urandom_range(99) < 14) begin
        s_axis_tvalid <= 0;
        @(posedge clk_i);
      end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(c);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) src.push_back(s[i]);
  endtask

  function automatic byte pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic add_word();
    int n;
    n = $urandom_range(1, 7);
    src.push_back(pick("abcdefghijklmnopqrstuvwxyzABCZ"));
    for (int i = 1; i < n; i++) src.push_back(pick("aeiourtnlsfbv_09Z"));
  endtask

  task automatic add_phrase();
    case ($urandom_range(9))
      0: begin
        if ($urandom_range(1)) add_text("true");
        else add_text("false");
      end
      1: begin
        case ($urandom_range(9))
          0: add_text("if"); 1: add_text("else"); 2: add_text("then");
          3: add_text("end"); 4: add_text("not"); 5: add_text("var");
          6: add_text("int"); 7: add_text("bool"); 8: add_text("true");
          default: add_text("false");
        endcase
      end
      2: add_word();
      3: begin
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) src.push_back(pick("0123456789"));
        if ($urandom_range(4) == 0) add_text("x_1");
      end
      4: begin
        int n;
        src.push_back("\"");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          byte c;
          c = byte'($urandom_range(1, 255));
          src.push_back(c == "\"" ? "a" : c);
        end
        src.push_back("\"");
      end
      5, 6: begin
        src.push_back(pick("=<>+-*/!()::"));
        if ($urandom_range(1)) src.push_back("=");
      end
      7: src.push_back(byte'($urandom_range(1, 255)));
      default: src.push_back(pick(" \t\n\r\v\f"));
    endcase
    if ($urandom_range(1)) src.push_back(pick("  \n\t"));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= !hold_off && (no_idle || $urandom_range(99) >= 14);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.ival = m_axis_tdata[30:0];
        got.sat  = m_axis_tdata[31];
        got.off  = m_axis_tdata[55:32];
        got.len  = m_axis_tdata[79:56];
        got.line = m_axis_tdata[99:80];
        got.col  = m_axis_tdata[115:100];
        got.err  = m_axis_tdata[117:116];
        got.bad  = m_axis_tdata[125:118];
        got.lst  = m_axis_tlast;
        sb.check_token(got);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000 && !(stim_done && sb.expq.size() == 0)) begin
        $display("** byte_stream_tokenizer: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int n;
    sb = new();
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = 0;
    no_idle = 0; hold_off = 0; stim_done = 0; quiet_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    add_text("if else then end not var int bool true false\n");
    add_text("(x1_a):=a==b!=c<d<=e>f>=g+h+=i-j-=k*l*=m/n/=o \"st\xff\"");
    add_text(" 99999999999 2147483647 0 12ab3\x80 ");
    src.push_back(0);
    add_text("\"open"); src.push_back(0);
    add_text("!x more"); src.push_back(0);
    add_text("!"); src.push_back(0);
    add_text("a_ _b"); src.push_back(0);
    add_text("#"); src.push_back(0);
    src.push_back(8'hFF); src.push_back(0);
    add_text("1 ok"); src.push_back(0);
    foreach (src[i]) send_byte(src[i]);

    n = src.size();
    while (n < 1450) begin
      src.delete();
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 8)) src.push_back(byte'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 12)) add_phrase();
      end
      if ($urandom_range(3) != 0) src.push_back(0);
      no_idle = (n > 600 && n < 800);
      foreach (src[i]) begin
        send_byte(src[i]);
        n++;
      end
    end
    src.delete();
    add_text("x"); src.push_back(0);
    foreach (src[i]) send_byte(src[i]);
    s_axis_tvalid <= 0;
    stim_done = 1;
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("** byte_stream_tokenizer: PASSED **");
    else
      $display("** byte_stream_tokenizer: FAILED **");
    $finish;
  end

  initial begin
    int stall;
    wait (rst_ni);
    repeat (400) @(posedge clk_i);
    stall = 0;
    hold_off <= 1;
    while (stall < 300) begin
      @(posedge clk_i);
      stall++;
    end
    hold_off <= 0;
  end

endmodule
